// ===== sv/bpsu_pkg.sv =====
// shared types and constants for the bmp pixel stream unpacker
package bpsu_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;

   // header byte offsets where a little-endian field is complete
   localparam logic [5:0] OFF_WIDTH_END  = 6'h15;
   localparam logic [5:0] OFF_HEIGHT_END = 6'h19;
   localparam logic [5:0] OFF_DEPTH_END  = 6'h1D;
   localparam logic [5:0] HDR_LAST       = 6'd53;

   localparam logic [15:0] DEPTH_24 = 16'd24;
   localparam logic [15:0] DEPTH_32 = 16'd32;

   typedef enum logic [1:0] {
      STATUS_PIXEL     = 2'd0,
      STATUS_BAD_DEPTH = 2'd1,
      STATUS_BAD_DIM   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      DRAW_ALL        = 2'd0,
      DRAW_SKIP_BLACK = 2'd1,
      DRAW_WINDOW     = 2'd2
   } draw_mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_DRAW_MODE  = 3'd2,
      CSR_CLIP_X_END = 3'd3,
      CSR_CLIP_Y_END = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [1:0]  draw_mode;
      logic [14:0] clip_x_end;
      logic [15:0] clip_y_end;
   } cfg_type;

   typedef struct packed {
      logic [13:0] screen_x;
      logic [13:0] screen_y;
      logic [31:0] pixel_color;
      status_type  status;
   } rsp_type;

endpackage

// ===== sv/bpsu_csr.sv =====
// configuration registers written through the plain csr port
module bpsu_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bpsu_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [bpsu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output bpsu_pkg::cfg_type                 cfg
);
   import bpsu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata[11:0];
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata[11:0];
            CSR_DRAW_MODE:  cfg_in.draw_mode  = csr_wdata[1:0];
            CSR_CLIP_X_END: cfg_in.clip_x_end = csr_wdata[14:0];
            CSR_CLIP_Y_END: cfg_in.clip_y_end = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/bpsu_parser.sv =====
// header capture, pixel assembly, row padding and coordinate generation
module bpsu_parser #(
   parameter int MAX_DIM = bpsu_pkg::MAX_DIM_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        data_byte,
   input  logic              start_of_file,
   input  bpsu_pkg::cfg_type cfg,
   output logic              res_valid,
   output bpsu_pkg::rsp_type res
);
   import bpsu_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 2);
   localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);
   localparam logic [DIM_W-1:0] DIM_OVER  = DIM_W'(MAX_DIM + 1);

   function automatic logic [DIM_W-1:0] dim_mag(input logic [31:0] w);
      logic [31:0] m;
      m = w[31] ? (32'd0 - w) : w;
      if (m > 32'(MAX_DIM)) begin
         return DIM_OVER;
      end
      return m[DIM_W-1:0];
   endfunction

   logic [5:0]       hdr_off_ff, hdr_off_in, c_off;
   logic [31:0]      hdr_shift_ff, hdr_shift_in, c_shift;
   logic [DIM_W-1:0] width_ff, width_in, c_width;
   logic [DIM_W-1:0] height_ff, height_in, c_height;
   logic             four_ff, four_in, c_four;
   logic             in_pix_ff, in_pix_in, c_in_pix;
   logic             halted_ff, halted_in, c_halted;
   logic [1:0]       phase_ff, phase_in, c_phase;
   logic [1:0]       pad_ff, pad_in, c_pad;
   logic [23:0]      accum_ff, accum_in, c_accum;
   logic [DIM_W-1:0] col_ff, col_in, c_col;
   logic [DIM_W-1:0] row_ff, row_in, c_row;

   logic [31:0]      shift_new;
   logic [15:0]      depth;
   logic             hdr_go;
   logic [DIM_W-1:0] row_inc;
   logic             row_done;
   logic [DIM_W-1:0] col_inc;
   logic [1:0]       last_phase;
   logic [23:0]      accum_new;
   logic [31:0]      color;
   logic             draw;
   logic             clip_x_ok;
   logic             clip_y_ok;

   // start of file clears the parse state before this beat is used
   always_comb begin
      c_off    = start_of_file ? '0 : hdr_off_ff;
      c_shift  = start_of_file ? '0 : hdr_shift_ff;
      c_width  = start_of_file ? '0 : width_ff;
      c_height = start_of_file ? '0 : height_ff;
      c_four   = start_of_file ? 1'b0 : four_ff;
      c_in_pix = start_of_file ? 1'b0 : in_pix_ff;
      c_halted = start_of_file ? 1'b0 : halted_ff;
      c_phase  = start_of_file ? '0 : phase_ff;
      c_pad    = start_of_file ? '0 : pad_ff;
      c_accum  = start_of_file ? '0 : accum_ff;
      c_col    = start_of_file ? '0 : col_ff;
      c_row    = start_of_file ? '0 : row_ff;
   end

   always_comb begin
      shift_new  = {data_byte, c_shift[31:8]};
      depth      = shift_new[31:16];
      row_inc    = c_row + 1'b1;
      row_done   = (row_inc >= c_height);
      col_inc    = c_col + 1'b1;
      last_phase = c_four ? 2'd3 : 2'd2;
      case (c_phase)
         2'd0:    accum_new = {16'h0000, data_byte};
         2'd1:    accum_new = c_accum | {8'h00, data_byte, 8'h00};
         2'd2:    accum_new = c_accum | {data_byte, 16'h0000};
         default: accum_new = c_accum;
      endcase
      color     = {(c_four ? data_byte : 8'h00), accum_new};
      clip_x_ok = (16'(c_col) < {1'b0, cfg.clip_x_end});
      clip_y_ok = ($signed({1'b0, 16'(c_row)}) > $signed({cfg.clip_y_end[15], cfg.clip_y_end}));
      case (cfg.draw_mode)
         DRAW_SKIP_BLACK: draw = (color != 32'h0);
         DRAW_WINDOW:     draw = clip_x_ok && clip_y_ok;
         default:         draw = 1'b1;
      endcase
   end

   always_comb begin
      hdr_off_in   = c_off;
      hdr_shift_in = c_shift;
      width_in     = c_width;
      height_in    = c_height;
      four_in      = c_four;
      in_pix_in    = c_in_pix;
      halted_in    = c_halted;
      phase_in     = c_phase;
      pad_in       = c_pad;
      accum_in     = c_accum;
      col_in       = c_col;
      row_in       = c_row;
      hdr_go       = 1'b0;
      res_valid    = 1'b0;
      res          = '0;
      res.status   = STATUS_PIXEL;

      if (c_halted) begin
         hdr_go = 1'b0;
      end else if (!c_in_pix) begin
         hdr_shift_in = shift_new;
         hdr_go       = 1'b1;
         if (c_off == OFF_WIDTH_END) begin
            width_in = dim_mag(shift_new);
         end else if (c_off == OFF_HEIGHT_END) begin
            height_in = dim_mag(shift_new);
         end else if (c_off == OFF_DEPTH_END) begin
            if (depth != DEPTH_24 && depth != DEPTH_32) begin
               res_valid  = 1'b1;
               res.status = STATUS_BAD_DEPTH;
               halted_in  = 1'b1;
               hdr_go     = 1'b0;
            end else if (c_width > DIM_LIMIT || c_height > DIM_LIMIT) begin
               res_valid  = 1'b1;
               res.status = STATUS_BAD_DIM;
               halted_in  = 1'b1;
               hdr_go     = 1'b0;
            end else begin
               four_in = (depth == DEPTH_32);
               // empty image: nothing to draw
               if (c_width == '0 || c_height == '0) begin
                  halted_in = 1'b1;
                  hdr_go    = 1'b0;
               end
            end
         end
         if (hdr_go) begin
            if (c_off == HDR_LAST) begin
               in_pix_in = 1'b1;
            end else begin
               hdr_off_in = c_off + 6'd1;
            end
         end
      end else if (c_pad != 2'd0) begin
         pad_in = c_pad - 2'd1;
         if (c_pad == 2'd1) begin
            row_in    = row_inc;
            halted_in = row_done;
         end
      end else begin
         accum_in = accum_new;
         if (c_phase < last_phase) begin
            phase_in = c_phase + 2'd1;
         end else begin
            phase_in = 2'd0;
            if (col_inc >= c_width) begin
               col_in = '0;
               // 24-bit rows pad to four bytes: pad count equals width mod 4
               if (!c_four && c_width[1:0] != 2'd0) begin
                  pad_in = c_width[1:0];
               end else begin
                  row_in    = row_inc;
                  halted_in = row_done;
               end
            end else begin
               col_in = col_inc;
            end
            if (draw) begin
               res_valid       = 1'b1;
               res.screen_x    = {{2{cfg.origin_x[11]}}, cfg.origin_x} + 14'(c_col);
               res.screen_y    = {{2{cfg.origin_y[11]}}, cfg.origin_y} + 14'(c_height)
                                 - 14'd1 - 14'(c_row);
               res.pixel_color = color;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_off_ff   <= '0;
         hdr_shift_ff <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         four_ff      <= 1'b0;
         in_pix_ff    <= 1'b0;
         halted_ff    <= 1'b0;
         phase_ff     <= '0;
         pad_ff       <= '0;
         accum_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else if (step) begin
         hdr_off_ff   <= hdr_off_in;
         hdr_shift_ff <= hdr_shift_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         four_ff      <= four_in;
         in_pix_ff    <= in_pix_in;
         halted_ff    <= halted_in;
         phase_ff     <= phase_in;
         pad_ff       <= pad_in;
         accum_ff     <= accum_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

endmodule

// ===== sv/bmp_pixel_stream_unpacker.sv =====
// bmp pixel stream unpacker top level: input register, parser, result register
// a byte accepted into the input register is parsed, and its result beat is registered into the result register on rsp
// throughput: one byte per cycle while rsp is not stalled, set by the single-pass parser between the registers
// at most one result beat per byte; input stalls only while a result waits and a byte is held
// reset (synchronous, active high) clears config, parse state and the valid flags of both pipeline registers
// parsing starts at byte zero after reset even without start_of_file
module bmp_pixel_stream_unpacker #(
   parameter int MAX_DIM = bpsu_pkg::MAX_DIM_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bpsu_pkg::REQ_TDATA_W-1:0]   req_tdata,   // data_byte
   input  logic                               req_tuser,   // start_of_file
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bpsu_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // screen_x, screen_y, pixel_color
   output logic [bpsu_pkg::RSP_TUSER_W-1:0]   rsp_tuser,   // status
   input  logic                               csr_we,
   input  logic [bpsu_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [bpsu_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bpsu_pkg::*;

   cfg_type    cfg;
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_sof_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic       stall;
   logic       step;
   logic       res_valid;
   rsp_type    res;

   bpsu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpsu_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (s1_byte_ff),
      .start_of_file (s1_sof_ff),
      .cfg           (cfg),
      .res_valid     (res_valid),
      .res           (res)
   );

   assign stall      = rsp_valid_ff && !rsp_tready;
   assign step       = s1_valid_ff && !stall;
   assign req_tready = !s1_valid_ff || !stall;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = stall ? 1'b1 : (step && res_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_sof_ff  <= req_tuser;
      end
      if (step && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_ff.pixel_color, rsp_ff.screen_y, rsp_ff.screen_x};
   assign rsp_tuser  = rsp_ff.status;

endmodule

// ===== sv/bpsu_checker.sv =====
// port-level checks for the bmp pixel stream unpacker, bound to the top level
module bpsu_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bpsu_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [bpsu_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import bpsu_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // error beats carry no coordinates or color
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_PIXEL |-> rsp_tdata == '0)
      else $error("error beat with nonzero data");

   // with no result pending the input side never stalls
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind bmp_pixel_stream_unpacker bpsu_checker u_bpsu_checker (.*);
